### rtl/masked_route_table_lookup_assert.svh
// Assertion macros for the route table lookup checker.
// Needs a clock named clk and a reset named rst in the scope of use.
`ifndef MASKED_ROUTE_TABLE_LOOKUP_ASSERT_SVH
`define MASKED_ROUTE_TABLE_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MRTL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route table lookup: check failed");

// Next-cycle implication, disabled during reset.
`define MRTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route table lookup: check failed");

`endif

### rtl/mrtl_pkg.sv
// Shared types and constants for the route table lookup block.
// No dependencies.
package mrtl_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int MIDX_W          = 6;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_APPENDED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [31:0] ifx;
  } entry_t;

endpackage

### rtl/mrtl_table.sv
// Route entry memory: one write port, one read port with registered data.
// Depends on mrtl_pkg for the entry type.
module mrtl_table #(
  parameter int TABLE_DEPTH = mrtl_pkg::TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  mrtl_pkg::entry_t      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output mrtl_pkg::entry_t      rdata
);

  mrtl_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mrtl_seq.sv
// Sequencer and shared match unit: appends entries, scans newest to oldest.
// Depends on mrtl_pkg; drives the ports of mrtl_table.
module mrtl_seq #(
  parameter int TABLE_DEPTH = mrtl_pkg::TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [31:0]           address,
  input  logic [31:0]           mask,
  input  logic [31:0]           next_hop,
  input  logic [31:0]           if_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [mrtl_pkg::MIDX_W-1:0] match_index,
  output logic [31:0]           route_dest,
  output logic [31:0]           route_mask,
  output logic [31:0]           hop_out,
  output logic [31:0]           interface_out,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output mrtl_pkg::entry_t      wdata,
  output logic                  re,
  output logic [AW-1:0]         raddr,
  input  mrtl_pkg::entry_t      rdata
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 left;
  logic                          pend;
  logic [AW-1:0]                 pidx;
  logic [31:0]                   key;
  mrtl_pkg::status_t             res_status;
  logic [mrtl_pkg::MIDX_W-1:0]   res_index;
  mrtl_pkg::entry_t              res_entry;
  logic                          hit;
  logic                          full;
  logic                          accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(TABLE_DEPTH));
  assign hit      = ((key & rdata.mask) == rdata.dest);

  assign we    = accept && (cmd == mrtl_pkg::CMD_APPEND) && !full;
  assign waddr = count[AW-1:0];
  assign wdata = '{dest: address, mask: mask, hop: next_hop, ifx: if_index};
  assign re    = (state == S_SCAN) && (left != '0);
  assign raddr = AW'(left - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == mrtl_pkg::CMD_LOOKUP) begin
              key   <= address;
              left  <= count;
              pend  <= 1'b0;
              state <= S_SCAN;
            end else begin
              res_entry <= '0;
              if (full) begin
                res_status <= mrtl_pkg::ST_FULL;
                res_index  <= '0;
              end else begin
                res_status <= mrtl_pkg::ST_APPENDED;
                res_index  <= mrtl_pkg::MIDX_W'(count[AW-1:0]);
                count      <= count + 1'b1;
              end
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          // issue the next read while the previous one is compared
          if (left != '0) begin
            left <= left - 1'b1;
            pidx <= raddr;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && hit) begin
            res_status <= mrtl_pkg::ST_HIT;
            res_index  <= mrtl_pkg::MIDX_W'(pidx);
            res_entry  <= rdata;
            state      <= S_DONE;
          end else if (left == '0) begin
            res_status <= mrtl_pkg::ST_MISS;
            res_index  <= '0;
            res_entry  <= '0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            match_index   <= res_index;
            route_dest    <= res_entry.dest;
            route_mask    <= res_entry.mask;
            hop_out       <= res_entry.hop;
            interface_out <= res_entry.ifx;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/masked_route_table_lookup.sv
// Masked route table lookup: append route entries, look up addresses.
// Input channel in_valid/in_stall carries one command beat: cmd 0 appends
// (address, mask, next_hop, if_index) into the next free slot, cmd 1 looks
// up address. Output channel out_valid/out_stall carries one result beat
// per command: status, match_index and the matched entry's fields.
// A lookup scans stored entries newest to oldest through one registered
// memory read port and a single mask-and-compare unit, one entry a cycle;
// the first match wins. A hit stops the scan; a miss reads every stored
// entry. The result goes through a result register, then the output
// register. The next command is taken the cycle after the result is
// registered in the output register.
// One command is in work at a time; in_stall is high from accept until the
// result moves into the output register.
// A finished result waits in the output register while out_stall is high,
// payload held; the next command can be accepted meanwhile.
// Reset (rst, synchronous) empties the table; entry memory is not cleared,
// the scan only reads slots that were written.
// Depends on mrtl_pkg, mrtl_seq and mrtl_table.
module masked_route_table_lookup #(
  parameter int TABLE_DEPTH = mrtl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [31:0]           address,
  input  logic [31:0]           mask,
  input  logic [31:0]           next_hop,
  input  logic [31:0]           if_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [mrtl_pkg::MIDX_W-1:0] match_index,
  output logic [31:0]           route_dest,
  output logic [31:0]           route_mask,
  output logic [31:0]           hop_out,
  output logic [31:0]           interface_out
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic             we;
  logic [AW-1:0]    waddr;
  mrtl_pkg::entry_t wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  mrtl_pkg::entry_t rdata;

  mrtl_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .address       (address),
    .mask          (mask),
    .next_hop      (next_hop),
    .if_index      (if_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .match_index   (match_index),
    .route_dest    (route_dest),
    .route_mask    (route_mask),
    .hop_out       (hop_out),
    .interface_out (interface_out),
    .we            (we),
    .waddr         (waddr),
    .wdata         (wdata),
    .re            (re),
    .raddr         (raddr),
    .rdata         (rdata)
  );

  mrtl_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

### rtl/masked_route_table_lookup_chk.sv
// Port-level checker for the route table lookup block, bound to the top.
// Depends on mrtl_pkg and masked_route_table_lookup_assert.svh.
`include "masked_route_table_lookup_assert.svh"

module masked_route_table_lookup_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [5:0]  match_index,
  input logic [31:0] route_dest,
  input logic [31:0] route_mask,
  input logic [31:0] hop_out,
  input logic [31:0] interface_out
);

  logic no_route;

  assign no_route = (route_dest == '0) && (route_mask == '0) &&
                    (hop_out == '0) && (interface_out == '0);

  // a command beat keeps the block busy for at least the next cycle
  `MRTL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  `MRTL_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(status) && $stable(match_index) &&
                    $stable(route_dest) && $stable(hop_out))

  `MRTL_ASSERT_NOW(a_miss_full_zero,
                   out_valid && (status == mrtl_pkg::ST_MISS || status == mrtl_pkg::ST_FULL),
                   no_route && (match_index == '0))

  `MRTL_ASSERT_NOW(a_append_zero, out_valid && (status == mrtl_pkg::ST_APPENDED), no_route)

endmodule

bind masked_route_table_lookup masked_route_table_lookup_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .match_index   (match_index),
  .route_dest    (route_dest),
  .route_mask    (route_mask),
  .hop_out       (hop_out),
  .interface_out (interface_out)
);
